// File: design/assert_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// A condition that, once seen, forces another one at the next clock edge.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/sgpsc_pkg.sv
// Package of the stereo gain, pan and soft-clip output unit: widths, codes and types.
`timescale 1ns / 1ps

package sgpsc_pkg;

  localparam int SAMPLE_FRAC_BITS_DEF = 20;
  localparam int SAMPLE_W  = 24;
  localparam int GAIN_W    = 17;
  localparam int GAIN_FRAC = 16;
  localparam logic [GAIN_W-1:0] GAIN_RESET = 17'd65536;

  // master * midi >> 16, then times pan >> 16.
  localparam int MM_W = 2 * GAIN_W - GAIN_FRAC;
  localparam int G_W  = MM_W + GAIN_W - GAIN_FRAC;
  // The magnitude is at most 2^23, so the top product bit is always zero.
  localparam int V_W  = SAMPLE_W + G_W - GAIN_FRAC - 1;

  localparam int Q_W = 15;
  localparam logic [Q_W-1:0] OUT_SCALE = 15'd32767;
  localparam int WORD_W = 32;
  localparam int HALF_W = 16;

  localparam int CFG_INDEX_W = 8;

  localparam int DIV_QB_DEF = 17;
  localparam int DIV_DW_DEF = 27;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_MASTER_GAIN    = 8'd0,
    REG_MIDI_GAIN      = 8'd1,
    REG_PAN_LEFT_GAIN  = 8'd2,
    REG_PAN_RIGHT_GAIN = 8'd3
  } cfg_reg_t;

  typedef struct packed {
    logic valid;
    logic last;
  } ctl_t;

  typedef struct packed {
    logic           neg;
    logic           over;
    logic [V_W-1:0] v;
  } lane_side_t;

endpackage

// File: design/sgpsc_div.sv
// Two-lane pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps

module sgpsc_div #(
  parameter int QB = sgpsc_pkg::DIV_QB_DEF,
  parameter int DW = sgpsc_pkg::DIV_DW_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             en,
  input  sgpsc_pkg::ctl_t                  ctl_i,
  input  sgpsc_pkg::lane_side_t [1:0]      side_i,
  input  logic [1:0][DW-1:0]               rem_i,
  input  logic [1:0][QB-1:0]               nlow_i,
  input  logic [1:0][DW-1:0]               den_i,
  output sgpsc_pkg::ctl_t                  ctl_o,
  output sgpsc_pkg::lane_side_t [1:0]      side_o,
  output logic [1:0][QB-1:0]               quo_o
);

  sgpsc_pkg::ctl_t                  ctl_r  [QB];
  sgpsc_pkg::lane_side_t [1:0]      side_r [QB];
  logic [1:0][QB-1:0]               quo_r  [QB];
  // The last stage keeps no remainder, numerator bits or divisor.
  logic [1:0][DW-1:0]               rem_r  [QB-1];
  logic [1:0][QB-1:0]               nlow_r [QB-1];
  logic [1:0][DW-1:0]               den_r  [QB-1];

  genvar s;
  for (s = 0; s < QB; s++) begin : g_step
    sgpsc_pkg::ctl_t             ctl_in;
    sgpsc_pkg::lane_side_t [1:0] side_in;
    logic [1:0][DW-1:0]          rem_in;
    logic [1:0][DW-1:0]          den_in;
    logic [1:0][QB-1:0]          nlow_in;
    logic [1:0][QB-1:0]          quo_in;
    logic [1:0][QB-1:0]          quo_nxt;
    logic [1:0][DW:0]            sh;
    logic [1:0]                  ge;

    if (s == 0) begin : g_first
      assign ctl_in  = ctl_i;
      assign side_in = side_i;
      assign rem_in  = rem_i;
      assign den_in  = den_i;
      assign nlow_in = nlow_i;
      assign quo_in  = '0;
    end else begin : g_next
      assign ctl_in  = ctl_r[s-1];
      assign side_in = side_r[s-1];
      assign rem_in  = rem_r[s-1];
      assign den_in  = den_r[s-1];
      assign nlow_in = nlow_r[s-1];
      assign quo_in  = quo_r[s-1];
    end

    // Bring down the next numerator bit and try the subtraction.
    always_comb begin
      for (int l = 0; l < 2; l++) begin
        sh[l]          = {rem_in[l], nlow_in[l][QB-1-s]};
        ge[l]          = (sh[l] >= {1'b0, den_in[l]});
        quo_nxt[l]     = quo_in[l];
        quo_nxt[l][QB-1-s] = ge[l];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ctl_r[s] <= '0;
      end else if (en) begin
        ctl_r[s] <= ctl_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side_r[s] <= side_in;
        quo_r[s]  <= quo_nxt;
      end
    end

    if (s < QB - 1) begin : g_mid
      logic [1:0][DW:0]   diff;
      logic [1:0][DW-1:0] rem_nxt;

      always_comb begin
        for (int l = 0; l < 2; l++) begin
          diff[l]    = sh[l] - {1'b0, den_in[l]};
          rem_nxt[l] = ge[l] ? diff[l][DW-1:0] : sh[l][DW-1:0];
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[s]  <= rem_nxt;
          nlow_r[s] <= nlow_in;
          den_r[s]  <= den_in;
        end
      end
    end
  end

  assign ctl_o  = ctl_r[QB-1];
  assign side_o = side_r[QB-1];
  assign quo_o  = quo_r[QB-1];

endmodule

// File: design/stereo_gain_pan_soft_clip_output_unit.sv
// Stereo output stage: gain, pan, rational soft clip and 16-bit word packing.
//
// Input channel (in_*): one stereo frame per word, two signed samples with
// SAMPLE_FRAC_BITS fraction bits and a last-frame mark. Result channel
// (out_*): two 32-bit words with the clipped 16-bit sample in the upper half.
// Both channels use valid and stall; a word moves when valid is high and
// stall is low. The config channel (cfg_*) writes one of four 17-bit gains
// by index; cfg_ready is always high and unknown indexes are dropped. Gains
// may only change while no frame is in flight.
// Throughput is one frame per cycle while no result is held. The accepting
// edge loads the first of six arithmetic stages, and the word then passes
// the other five, one divider stage per quotient bit and the output
// register; QB, the quotient width of the soft-clip division, is 17 bits
// at 20 fraction bits.
// When out_stall holds a pending result, the whole pipeline freezes and
// in_stall rises in the same cycle; nothing is lost or repeated.
// Reset empties the pipeline and sets every gain to unity (65536).
`timescale 1ns / 1ps

module stereo_gain_pan_soft_clip_output_unit #(
  parameter int SAMPLE_FRAC_BITS = sgpsc_pkg::SAMPLE_FRAC_BITS_DEF
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      in_valid,
  output logic                                      in_stall,
  input  logic signed [sgpsc_pkg::SAMPLE_W-1:0]     in_left_sample,
  input  logic signed [sgpsc_pkg::SAMPLE_W-1:0]     in_right_sample,
  input  logic                                      in_frame_last,
  output logic                                      out_valid,
  input  logic                                      out_stall,
  output logic signed [sgpsc_pkg::WORD_W-1:0]       out_left_word,
  output logic signed [sgpsc_pkg::WORD_W-1:0]       out_right_word,
  output logic                                      out_frame_last_out,
  input  logic                                      cfg_valid,
  output logic                                      cfg_ready,
  input  logic [sgpsc_pkg::CFG_INDEX_W-1:0]         cfg_index,
  input  logic [sgpsc_pkg::GAIN_W-1:0]              cfg_data
);

  localparam int     F       = SAMPLE_FRAC_BITS;
  localparam longint KNEE_L  = (longint'(9) << F) / 10;
  localparam longint RANGE_L = (longint'(1) << F) - KNEE_L;
  localparam int     RW      = $clog2(RANGE_L + 1);
  localparam int     QB      = $clog2(RANGE_L);
  localparam int     VW      = sgpsc_pkg::V_W;
  localparam int     NW      = RW + VW;
  localparam int     DW      = ((RW > VW) ? RW : VW) + 1;
  localparam int     YW      = ((F > VW) ? F : VW) + 1;
  localparam int     PW      = YW + sgpsc_pkg::Q_W;
  localparam int     SW      = sgpsc_pkg::SAMPLE_W;
  localparam int     GW      = sgpsc_pkg::GAIN_W;
  localparam int     GF      = sgpsc_pkg::GAIN_FRAC;
  localparam int     MMW     = sgpsc_pkg::MM_W;
  localparam int     GGW     = sgpsc_pkg::G_W;
  localparam int     QW      = sgpsc_pkg::Q_W;
  localparam int     WW      = sgpsc_pkg::WORD_W;

  localparam logic [YW-1:0] KNEE_Y  = YW'(KNEE_L);
  localparam logic [RW-1:0] RANGE_R = RW'(RANGE_L);

  // Gain registers.
  logic [GW-1:0] master_r, midi_r, pan_left_r, pan_right_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      master_r    <= sgpsc_pkg::GAIN_RESET;
      midi_r      <= sgpsc_pkg::GAIN_RESET;
      pan_left_r  <= sgpsc_pkg::GAIN_RESET;
      pan_right_r <= sgpsc_pkg::GAIN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        sgpsc_pkg::REG_MASTER_GAIN:    master_r    <= cfg_data;
        sgpsc_pkg::REG_MIDI_GAIN:      midi_r      <= cfg_data;
        sgpsc_pkg::REG_PAN_LEFT_GAIN:  pan_left_r  <= cfg_data;
        sgpsc_pkg::REG_PAN_RIGHT_GAIN: pan_right_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // One enable for the whole pipeline: it only stops for a held result.
  sgpsc_pkg::ctl_t out_ctl_r;
  logic            en;

  assign en       = !(out_ctl_r.valid && out_stall);
  assign in_stall = out_ctl_r.valid && out_stall;

  // Stage 1: sample magnitudes and master times MIDI gain.
  sgpsc_pkg::ctl_t     s1_ctl_r, s1_ctl_nxt;
  logic [1:0][SW-1:0]  s1_mag_r, s1_mag_nxt;
  logic [1:0]          s1_neg_r, s1_neg_nxt;
  logic [MMW-1:0]      s1_mm_r, s1_mm_nxt;
  logic [1:0][SW-1:0]  samp;
  logic [2*GW-1:0]     mm_prod;

  always_comb begin
    samp[0]          = in_left_sample;
    samp[1]          = in_right_sample;
    s1_ctl_nxt.valid = in_valid;
    s1_ctl_nxt.last  = in_frame_last;
    for (int l = 0; l < 2; l++) begin
      s1_neg_nxt[l] = samp[l][SW-1];
      s1_mag_nxt[l] = samp[l][SW-1] ? SW'(~samp[l] + 1'b1) : samp[l];
    end
    mm_prod   = master_r * midi_r;
    s1_mm_nxt = mm_prod[2*GW-1:GF];
  end

  // Stage 2: combined gain per channel.
  sgpsc_pkg::ctl_t     s2_ctl_r;
  logic [1:0][SW-1:0]  s2_mag_r;
  logic [1:0]          s2_neg_r;
  logic [1:0][GGW-1:0] s2_g_r, s2_g_nxt;
  logic [1:0][GW-1:0]  pan;
  logic [1:0][MMW+GW-1:0] g_prod;

  always_comb begin
    pan[0] = pan_left_r;
    pan[1] = pan_right_r;
    for (int l = 0; l < 2; l++) begin
      g_prod[l]   = s1_mm_r * pan[l];
      s2_g_nxt[l] = g_prod[l][MMW+GW-1:GF];
    end
  end

  // Stage 3: scaled magnitude.
  sgpsc_pkg::ctl_t        s3_ctl_r;
  logic [1:0]             s3_neg_r;
  logic [1:0][VW-1:0]     s3_v_r, s3_v_nxt;
  logic [1:0][SW+GGW-1:0] v_prod;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      v_prod[l]   = s2_mag_r[l] * s2_g_r[l];
      s3_v_nxt[l] = v_prod[l][GF+VW-1:GF];
    end
  end

  // Stage 4: knee test and excess over the knee.
  sgpsc_pkg::ctl_t    s4_ctl_r;
  logic [1:0]         s4_neg_r;
  logic [1:0][VW-1:0] s4_v_r;
  logic [1:0]         s4_over_r, s4_over_nxt;
  logic [1:0][VW-1:0] s4_e_r, s4_e_nxt;
  logic [1:0][YW-1:0] v_ext;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      v_ext[l]       = YW'(s3_v_r[l]);
      s4_over_nxt[l] = v_ext[l] > KNEE_Y;
      s4_e_nxt[l]    = s4_over_nxt[l] ? VW'(v_ext[l] - KNEE_Y) : '0;
    end
  end

  // Stage 5: numerator range*e and denominator range+e for the divider.
  sgpsc_pkg::ctl_t             s5_ctl_r;
  sgpsc_pkg::lane_side_t [1:0] s5_side_r, s5_side_nxt;
  logic [1:0][DW-1:0]          s5_rem_r, s5_rem_nxt;
  logic [1:0][QB-1:0]          s5_nlow_r, s5_nlow_nxt;
  logic [1:0][DW-1:0]          s5_den_r, s5_den_nxt;
  logic [1:0][NW-1:0]          n_full;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      n_full[l]           = NW'(RANGE_R) * NW'(s4_e_r[l]);
      s5_den_nxt[l]       = DW'(RANGE_R) + DW'(s4_e_r[l]);
      // The quotient stays below the range, so the high part is below the divisor.
      s5_rem_nxt[l]       = DW'(n_full[l][NW-1:QB]);
      s5_nlow_nxt[l]      = n_full[l][QB-1:0];
      s5_side_nxt[l].neg  = s4_neg_r[l];
      s5_side_nxt[l].over = s4_over_r[l];
      s5_side_nxt[l].v    = s4_v_r[l];
    end
  end

  // Divider stages.
  sgpsc_pkg::ctl_t             dv_ctl;
  sgpsc_pkg::lane_side_t [1:0] dv_side;
  logic [1:0][QB-1:0]          dv_quo;

  sgpsc_div #(
    .QB (QB),
    .DW (DW)
  ) u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .ctl_i  (s5_ctl_r),
    .side_i (s5_side_r),
    .rem_i  (s5_rem_r),
    .nlow_i (s5_nlow_r),
    .den_i  (s5_den_r),
    .ctl_o  (dv_ctl),
    .side_o (dv_side),
    .quo_o  (dv_quo)
  );

  // Stage 6: clipped value scaled by 32767. It stays below one full scale,
  // so the 15-bit result never reaches the 16-bit limits.
  sgpsc_pkg::ctl_t    s6_ctl_r;
  logic [1:0]         s6_neg_r;
  logic [1:0][QW-1:0] s6_q_r, s6_q_nxt;
  logic [1:0][YW-1:0] y_val;
  logic [1:0][PW-1:0] y_prod;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      y_val[l]    = dv_side[l].over ? YW'(KNEE_Y + YW'(dv_quo[l]))
                                    : YW'(dv_side[l].v);
      y_prod[l]   = PW'(y_val[l]) * PW'(sgpsc_pkg::OUT_SCALE);
      s6_q_nxt[l] = y_prod[l][F+QW-1:F];
    end
  end

  // Output stage: sign and packing into the upper half.
  logic [1:0][WW-1:0] out_word_r, out_word_nxt;
  logic [1:0][WW-1:0] mag_word;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      mag_word[l]     = {1'b0, s6_q_r[l], sgpsc_pkg::HALF_W'(0)};
      out_word_nxt[l] = s6_neg_r[l] ? WW'(0) - mag_word[l] : mag_word[l];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_ctl_r  <= '0;
      s2_ctl_r  <= '0;
      s3_ctl_r  <= '0;
      s4_ctl_r  <= '0;
      s5_ctl_r  <= '0;
      s6_ctl_r  <= '0;
      out_ctl_r <= '0;
    end else if (en) begin
      s1_ctl_r  <= s1_ctl_nxt;
      s2_ctl_r  <= s1_ctl_r;
      s3_ctl_r  <= s2_ctl_r;
      s4_ctl_r  <= s3_ctl_r;
      s5_ctl_r  <= s4_ctl_r;
      s6_ctl_r  <= dv_ctl;
      out_ctl_r <= s6_ctl_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_mag_r   <= s1_mag_nxt;
      s1_neg_r   <= s1_neg_nxt;
      s1_mm_r    <= s1_mm_nxt;
      s2_mag_r   <= s1_mag_r;
      s2_neg_r   <= s1_neg_r;
      s2_g_r     <= s2_g_nxt;
      s3_neg_r   <= s2_neg_r;
      s3_v_r     <= s3_v_nxt;
      s4_neg_r   <= s3_neg_r;
      s4_v_r     <= s3_v_r;
      s4_over_r  <= s4_over_nxt;
      s4_e_r     <= s4_e_nxt;
      s5_side_r  <= s5_side_nxt;
      s5_rem_r   <= s5_rem_nxt;
      s5_nlow_r  <= s5_nlow_nxt;
      s5_den_r   <= s5_den_nxt;
      s6_neg_r   <= {dv_side[1].neg, dv_side[0].neg};
      s6_q_r     <= s6_q_nxt;
      out_word_r <= out_word_nxt;
    end
  end

  assign out_valid          = out_ctl_r.valid;
  assign out_frame_last_out = out_ctl_r.last;
  assign out_left_word      = out_word_r[0];
  assign out_right_word     = out_word_r[1];

endmodule

// File: design/sgpsc_chk.sv
// Port-level checker of the stereo output unit and its bind to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sgpsc_chk (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_stall,
  input logic                               out_valid,
  input logic                               out_stall,
  input logic [sgpsc_pkg::WORD_W-1:0]       out_left_word,
  input logic [sgpsc_pkg::WORD_W-1:0]       out_right_word,
  input logic                               out_frame_last_out
);

  // The input side only waits behind a result word that is being held.
  `ASSERT_ALWAYS(a_stall_cause, in_stall |-> (out_valid && out_stall), "input stalled without a held result")

  // The lower half of every result word is zero.
  `ASSERT_ALWAYS(a_low_half_zero, out_valid |-> (out_left_word[15:0] == 16'h0000 && out_right_word[15:0] == 16'h0000), "nonzero lower half in result word")

  // The soft clip keeps the magnitude below full scale.
  `ASSERT_ALWAYS(a_below_full_scale, out_valid |-> (out_left_word[31:16] != 16'h8000 && out_left_word[31:16] != 16'h7fff && out_right_word[31:16] != 16'h8000 && out_right_word[31:16] != 16'h7fff), "result reached full scale")

  // A held result word stays put.
  `ASSERT_NEXT(a_hold, out_valid && out_stall, out_valid && $stable(out_left_word) && $stable(out_right_word) && $stable(out_frame_last_out), "held result word changed")

endmodule

bind stereo_gain_pan_soft_clip_output_unit sgpsc_chk u_chk (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_stall           (in_stall),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_left_word      (out_left_word),
  .out_right_word     (out_right_word),
  .out_frame_last_out (out_frame_last_out)
);
